### hw/rtl/rpn_pkg.sv
// Shared types, codes and constants of the RPN character-stream calculator.
package rpn_pkg;

   localparam int STACK_DEPTH_DEF = 128;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int WORD_BITS_DEF   = 48;

   localparam int CHAR_BITS       = 8;
   localparam int SLOT_INDEX_BITS = 7;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_BANG    = 8'h21;
   localparam logic [CHAR_BITS-1:0] CH_STAR    = 8'h2A;
   localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_SLASH   = 8'h2F;
   localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;

   typedef logic [3:0] op_type;

   localparam op_type OP_OTHER   = 4'd0;
   localparam op_type OP_DIGIT   = 4'd1;
   localparam op_type OP_ADD     = 4'd2;
   localparam op_type OP_SUB     = 4'd3;
   localparam op_type OP_MUL     = 4'd4;
   localparam op_type OP_DIV     = 4'd5;
   localparam op_type OP_SPACE   = 4'd6;
   localparam op_type OP_NEWLINE = 4'd7;
   localparam op_type OP_HALT    = 4'd8;

   typedef struct packed {
      op_type     op;
      logic [3:0] digit;
   } cmd_type;

   typedef struct packed {
      logic start;
      logic is_div;
      logic neg;
   } md_cmd_type;

endpackage

### hw/rtl/rpn_if.sv
// Valid/ready channel interfaces for character requests and result responses.
interface rpn_req_if;
   import rpn_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface rpn_rsp_if #(
   parameter int WORD_BITS = rpn_pkg::WORD_BITS_DEF
);
   import rpn_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [WORD_BITS-1:0] result_value;
   logic                       halted;
   logic                       div_by_zero_seen;
   logic                       saturation_seen;
   logic                       stack_full_seen;
   logic [SLOT_INDEX_BITS-1:0] slot_index;

   modport source (output valid, output result_value, output halted,
                   output div_by_zero_seen, output saturation_seen,
                   output stack_full_seen, output slot_index, input ready);
   modport sink (input valid, input result_value, input halted,
                 input div_by_zero_seen, input saturation_seen,
                 input stack_full_seen, input slot_index, output ready);
endinterface

### hw/rtl/rpn_front.sv
// Front end: accepts characters, classifies them into commands, drops input after halt.
module rpn_front (
   input  logic             clock,
   input  logic             reset,
   rpn_req_if.sink          req_port,
   output logic             push,
   output rpn_pkg::cmd_type push_cmd,
   input  logic             queue_full
);
   import rpn_pkg::*;

   logic halted_ff;
   logic halted_in;

   function automatic cmd_type classify(input logic [CHAR_BITS-1:0] c);
      cmd_type r;
      r.digit = 4'(c - CH_ZERO);
      r.op    = OP_OTHER;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         r.op = OP_DIGIT;
      end else begin
         unique case (c)
            CH_PLUS:    r.op = OP_ADD;
            CH_MINUS:   r.op = OP_SUB;
            CH_STAR:    r.op = OP_MUL;
            CH_SLASH:   r.op = OP_DIV;
            CH_SPACE:   r.op = OP_SPACE;
            CH_NEWLINE: r.op = OP_NEWLINE;
            CH_BANG:    r.op = OP_HALT;
            default:    r.op = OP_OTHER;
         endcase
      end
      return r;
   endfunction

   assign req_port.ready = halted_ff || !queue_full;
   assign push_cmd       = classify(req_port.char_code);
   assign push           = req_port.valid && !halted_ff && !queue_full;
   assign halted_in      = halted_ff || (push && push_cmd.op == OP_HALT);

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff <= 1'b0;
      end else begin
         halted_ff <= halted_in;
      end
   end

endmodule

### hw/rtl/rpn_queue.sv
// Short command queue between the front end and the execution back end.
module rpn_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rpn_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output rpn_pkg::cmd_type head,
   output logic             empty
);
   import rpn_pkg::*;

   localparam int QPW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [QPW-1:0]   wr_ptr_ff;
   logic [QPW-1:0]   wr_ptr_in;
   logic [QPW-1:0]   rd_ptr_ff;
   logic [QPW-1:0]   rd_ptr_in;
   logic [QCW-1:0]   count_ff;
   logic [QCW-1:0]   count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = count_ff == QCW'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/rpn_muldiv.sv
// Iterative shift-add multiplier and restoring divider on magnitudes, with saturation.
module rpn_muldiv #(
   parameter int FRAC_BITS = rpn_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = rpn_pkg::WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rpn_pkg::md_cmd_type  md_cmd,
   input  logic [WORD_BITS-1:0] md_a,
   input  logic [WORD_BITS-1:0] md_b,
   output logic                 done,
   output logic                 sat,
   output logic [WORD_BITS-1:0] res
);
   import rpn_pkg::*;

   localparam int NW    = WORD_BITS + FRAC_BITS;
   localparam int PRODW = 2 * WORD_BITS;
   localparam int MW    = (PRODW > NW) ? PRODW : NW;
   localparam int CW    = $clog2(NW + 1);

   localparam logic [MW-1:0] POS_LIM = (MW'(1) << (WORD_BITS - 1)) - MW'(1);
   localparam logic [MW-1:0] NEG_LIM = MW'(1) << (WORD_BITS - 1);
   localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

   localparam logic [1:0] U_IDLE = 2'd0;
   localparam logic [1:0] U_RUN  = 2'd1;
   localparam logic [1:0] U_FIN  = 2'd2;

   logic [1:0]           ustate_ff;
   logic [1:0]           ustate_in;
   logic [CW-1:0]        cnt_ff;
   logic [CW-1:0]        cnt_in;
   logic                 is_div_ff;
   logic                 is_div_in;
   logic                 neg_ff;
   logic                 neg_in;
   logic [WORD_BITS-1:0] opd_ff;
   logic [WORD_BITS-1:0] opd_in;
   logic [WORD_BITS-1:0] hi_ff;
   logic [WORD_BITS-1:0] hi_in;
   logic [WORD_BITS-1:0] lo_ff;
   logic [WORD_BITS-1:0] lo_in;
   logic [NW-1:0]        num_ff;
   logic [NW-1:0]        num_in;
   logic [WORD_BITS-1:0] rem_ff;
   logic [WORD_BITS-1:0] rem_in;
   logic                 done_ff;
   logic                 done_in;
   logic                 sat_ff;
   logic                 sat_in;
   logic [WORD_BITS-1:0] res_ff;
   logic [WORD_BITS-1:0] res_in;

   logic [WORD_BITS:0]   msum;
   logic [WORD_BITS:0]   dtry;
   logic [WORD_BITS:0]   dsub;
   logic                 dge;
   logic [PRODW-1:0]     prod;
   logic [MW-1:0]        mag;
   logic                 mag_sat;

   assign done = done_ff;
   assign sat  = sat_ff;
   assign res  = res_ff;

   assign msum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, opd_ff} : '0);
   assign dtry = {rem_ff, num_ff[NW-1]};
   assign dge  = dtry >= {1'b0, opd_ff};
   assign dsub = dtry - {1'b0, opd_ff};
   assign prod = {hi_ff, lo_ff};
   assign mag  = is_div_ff ? MW'(num_ff) : MW'(prod >> FRAC_BITS);
   assign mag_sat = neg_ff ? (mag > NEG_LIM) : (mag > POS_LIM);

   always_comb begin
      ustate_in = ustate_ff;
      cnt_in    = cnt_ff;
      is_div_in = is_div_ff;
      neg_in    = neg_ff;
      opd_in    = opd_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      done_in   = 1'b0;
      sat_in    = sat_ff;
      res_in    = res_ff;
      unique case (ustate_ff)
         U_IDLE: begin
            if (md_cmd.start) begin
               is_div_in = md_cmd.is_div;
               neg_in    = md_cmd.neg;
               hi_in     = '0;
               rem_in    = '0;
               if (md_cmd.is_div) begin
                  opd_in = md_b;
                  num_in = NW'(md_a) << FRAC_BITS;
                  cnt_in = CW'(NW);
               end else begin
                  opd_in = md_a;
                  lo_in  = md_b;
                  cnt_in = CW'(WORD_BITS);
               end
               ustate_in = U_RUN;
            end
         end
         U_RUN: begin
            if (is_div_ff) begin
               rem_in = dge ? dsub[WORD_BITS-1:0] : dtry[WORD_BITS-1:0];
               num_in = {num_ff[NW-2:0], dge};
            end else begin
               hi_in = msum[WORD_BITS:1];
               lo_in = {msum[0], lo_ff[WORD_BITS-1:1]};
            end
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               ustate_in = U_FIN;
            end
         end
         U_FIN: begin
            sat_in = mag_sat;
            if (mag_sat) begin
               res_in = neg_ff ? WMIN : WMAX;
            end else begin
               res_in = neg_ff ? -mag[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
            end
            done_in   = 1'b1;
            ustate_in = U_IDLE;
         end
         default: ustate_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ustate_ff <= U_IDLE;
         done_ff   <= 1'b0;
      end else begin
         ustate_ff <= ustate_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      is_div_ff <= is_div_in;
      neg_ff    <= neg_in;
      opd_ff    <= opd_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      sat_ff    <= sat_in;
      res_ff    <= res_in;
   end

endmodule

### hw/rtl/rpn_exec.sv
// Back end: slot memory, pointer, sticky flags, command sequencer and result register.
module rpn_exec #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
   parameter int FRAC_BITS   = rpn_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS   = rpn_pkg::WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  rpn_pkg::cmd_type     q_head,
   output logic                 q_pop,
   rpn_rsp_if.source            rsp_port,
   output rpn_pkg::md_cmd_type  md_cmd,
   output logic [WORD_BITS-1:0] md_a,
   output logic [WORD_BITS-1:0] md_b,
   input  logic                 md_done,
   input  logic                 md_sat,
   input  logic [WORD_BITS-1:0] md_res
);
   import rpn_pkg::*;

   localparam int PW = $clog2(STACK_DEPTH);
   localparam int W  = WORD_BITS;
   localparam int DW = ((W > FRAC_BITS + 4) ? W : FRAC_BITS + 4) + 1;

   localparam logic [W-1:0]   WMAX    = {1'b0, {(W - 1){1'b1}}};
   localparam logic [W-1:0]   WMIN    = {1'b1, {(W - 1){1'b0}}};
   localparam logic [W+3:0]   M10_POS = (W + 4)'(WMAX);
   localparam logic [W+3:0]   M10_NEG = M10_POS + (W + 4)'(1);
   localparam logic signed [DW-1:0] DMAX = $signed((DW'(1) << (W - 1)) - DW'(1));
   localparam logic signed [DW-1:0] DMIN = -DMAX - DW'(1);
   localparam logic [PW-1:0]  TOP     = PW'(STACK_DEPTH - 1);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_DIG_MUL = 4'd1;
   localparam logic [3:0] ST_DIG_ADD = 4'd2;
   localparam logic [3:0] ST_OP_L    = 4'd3;
   localparam logic [3:0] ST_OP_R    = 4'd4;
   localparam logic [3:0] ST_OP_EXEC = 4'd5;
   localparam logic [3:0] ST_OP_WAIT = 4'd6;
   localparam logic [3:0] ST_NEWLINE = 4'd7;
   localparam logic [3:0] ST_HALT    = 4'd8;
   localparam logic [3:0] ST_STOPPED = 4'd9;

   logic [W-1:0]  mem [STACK_DEPTH];
   logic [W-1:0]  mem_q_ff;
   logic          mem_we;
   logic [W-1:0]  mem_wd;
   logic [PW-1:0] rd_addr;

   logic [3:0]    state_ff;
   logic [3:0]    state_in;
   logic [PW-1:0] p_ff;
   logic [PW-1:0] p_in;
   logic          cur_wr_ff;
   logic          cur_wr_in;
   logic          pend_ff;
   logic          pend_in;
   logic          div_ff;
   logic          div_in;
   logic          sat_ff;
   logic          sat_in;
   logic          full_ff;
   logic          full_in;
   cmd_type       cmd_ff;
   cmd_type       cmd_in;
   logic [W-1:0]  opa_ff;
   logic [W-1:0]  opa_in;
   logic [W-1:0]  opb_ff;
   logic [W-1:0]  opb_in;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [W-1:0]               rsp_value_ff;
   logic [W-1:0]               rsp_value_in;
   logic                       rsp_halt_ff;
   logic                       rsp_halt_in;
   logic                       rsp_div_ff;
   logic                       rsp_div_in;
   logic                       rsp_sat_ff;
   logic                       rsp_sat_in;
   logic                       rsp_full_ff;
   logic                       rsp_full_in;
   logic [SLOT_INDEX_BITS-1:0] rsp_index_ff;
   logic [SLOT_INDEX_BITS-1:0] rsp_index_in;

   logic          out_free;
   logic          adv;
   logic          emit_nl;
   logic          emit_halt;
   logic          head_arith;
   logic [W-1:0]  cur_val;

   logic          dneg;
   logic [W-1:0]  dmag;
   logic [W+3:0]  m10;
   logic          m10_sat;
   logic [W-1:0]  m10_res;
   logic signed [DW-1:0] dsum;
   logic [W-1:0]  dsum_res;
   logic          dsum_sat;

   logic [W:0]    asum;
   logic          as_ovf;
   logic [W-1:0]  as_res;

   assign rsp_port.valid            = rsp_valid_ff;
   assign rsp_port.result_value     = rsp_value_ff;
   assign rsp_port.halted           = rsp_halt_ff;
   assign rsp_port.div_by_zero_seen = rsp_div_ff;
   assign rsp_port.saturation_seen  = rsp_sat_ff;
   assign rsp_port.stack_full_seen  = rsp_full_ff;
   assign rsp_port.slot_index       = rsp_index_ff;

   assign out_free   = !rsp_valid_ff || rsp_port.ready;
   assign cur_val    = cur_wr_ff ? mem_q_ff : '0;
   assign head_arith = q_head.op == OP_ADD || q_head.op == OP_SUB ||
                       q_head.op == OP_MUL || q_head.op == OP_DIV;

   // digit step one: magnitude times ten, saturated
   assign dneg    = cur_val[W-1];
   assign dmag    = dneg ? -cur_val : cur_val;
   assign m10     = ((W + 4)'(dmag) << 3) + ((W + 4)'(dmag) << 1);
   assign m10_sat = dneg ? (m10 > M10_NEG) : (m10 > M10_POS);
   assign m10_res = m10_sat ? (dneg ? WMIN : WMAX) :
                    (dneg ? -m10[W-1:0] : m10[W-1:0]);

   // digit step two: add the digit in fixed point
   assign dsum     = $signed(DW'($signed(opa_ff))) +
                     $signed(DW'(cmd_ff.digit) << FRAC_BITS);
   assign dsum_sat = (dsum > DMAX) || (dsum < DMIN);
   assign dsum_res = (dsum > DMAX) ? WMAX : ((dsum < DMIN) ? WMIN : dsum[W-1:0]);

   assign asum   = (cmd_ff.op == OP_SUB) ? {opa_ff[W-1], opa_ff} - {opb_ff[W-1], opb_ff} :
                                           {opa_ff[W-1], opa_ff} + {opb_ff[W-1], opb_ff};
   assign as_ovf = asum[W] != asum[W-1];
   assign as_res = as_ovf ? (asum[W] ? WMIN : WMAX) : asum[W-1:0];

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      cur_wr_in    = cur_wr_ff;
      pend_in      = pend_ff;
      div_in       = div_ff;
      sat_in       = sat_ff;
      full_in      = full_ff;
      cmd_in       = cmd_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_wd       = '0;
      rd_addr      = p_ff;
      adv          = 1'b0;
      emit_nl      = 1'b0;
      emit_halt    = 1'b0;
      md_cmd       = '0;
      md_a         = '0;
      md_b         = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_value_in = rsp_value_ff;
      rsp_halt_in  = rsp_halt_ff;
      rsp_div_in   = rsp_div_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_index_in = rsp_index_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               if (head_arith) begin
                  rd_addr = p_ff - PW'(2);
               end
               unique case (q_head.op)
                  OP_DIGIT: state_in = ST_DIG_MUL;
                  OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                     if (p_ff >= PW'(2)) begin
                        state_in = ST_OP_L;
                     end
                  end
                  OP_SPACE: begin
                     adv     = pend_ff;
                     pend_in = 1'b0;
                  end
                  OP_NEWLINE: state_in = ST_NEWLINE;
                  OP_HALT:    state_in = ST_HALT;
                  default:    pend_in  = 1'b0;
               endcase
            end
         end
         ST_DIG_MUL: begin
            opa_in   = m10_res;
            sat_in   = sat_ff || m10_sat;
            state_in = ST_DIG_ADD;
         end
         ST_DIG_ADD: begin
            mem_we    = 1'b1;
            mem_wd    = dsum_res;
            sat_in    = sat_ff || dsum_sat;
            cur_wr_in = 1'b1;
            pend_in   = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_OP_L: begin
            opa_in   = mem_q_ff;
            rd_addr  = p_ff - PW'(1);
            state_in = ST_OP_R;
         end
         ST_OP_R: begin
            opb_in   = mem_q_ff;
            state_in = ST_OP_EXEC;
         end
         ST_OP_EXEC: begin
            if (cmd_ff.op == OP_ADD || cmd_ff.op == OP_SUB) begin
               mem_we    = 1'b1;
               mem_wd    = as_res;
               sat_in    = sat_ff || as_ovf;
               cur_wr_in = 1'b1;
               pend_in   = 1'b1;
               state_in  = ST_IDLE;
            end else if (cmd_ff.op == OP_DIV && opb_ff == '0) begin
               mem_we    = 1'b1;
               mem_wd    = opa_ff[W-1] ? WMIN : WMAX;
               div_in    = 1'b1;
               cur_wr_in = 1'b1;
               pend_in   = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               md_cmd.start  = 1'b1;
               md_cmd.is_div = cmd_ff.op == OP_DIV;
               md_cmd.neg    = opa_ff[W-1] ^ opb_ff[W-1];
               md_a          = opa_ff[W-1] ? -opa_ff : opa_ff;
               md_b          = opb_ff[W-1] ? -opb_ff : opb_ff;
               state_in      = ST_OP_WAIT;
            end
         end
         ST_OP_WAIT: begin
            if (md_done) begin
               mem_we    = 1'b1;
               mem_wd    = md_res;
               sat_in    = sat_ff || md_sat;
               cur_wr_in = 1'b1;
               pend_in   = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_NEWLINE: begin
            if (out_free) begin
               emit_nl  = 1'b1;
               adv      = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_HALT: begin
            if (out_free) begin
               emit_halt = 1'b1;
               state_in  = ST_STOPPED;
            end
         end
         ST_STOPPED: state_in = ST_STOPPED;
         default:    state_in = ST_IDLE;
      endcase

      // advancing zeroes a slot that was never written, so every slot below the
      // pointer holds a defined value
      if (adv) begin
         if (p_ff != TOP) begin
            if (!cur_wr_ff) begin
               mem_we = 1'b1;
               mem_wd = '0;
            end
            p_in      = p_ff + PW'(1);
            cur_wr_in = 1'b0;
         end else begin
            full_in = 1'b1;
         end
      end

      if (emit_nl || emit_halt) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = emit_halt ? '0 : cur_val;
         rsp_halt_in  = emit_halt;
         rsp_div_in   = div_in;
         rsp_sat_in   = sat_in;
         rsp_full_in  = full_in;
         rsp_index_in = SLOT_INDEX_BITS'(p_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p_ff         <= '0;
         cur_wr_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         div_ff       <= 1'b0;
         sat_ff       <= 1'b0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p_ff         <= p_in;
         cur_wr_ff    <= cur_wr_in;
         pend_ff      <= pend_in;
         div_ff       <= div_in;
         sat_ff       <= sat_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      opa_ff       <= opa_in;
      opb_ff       <= opb_in;
      rsp_value_ff <= rsp_value_in;
      rsp_halt_ff  <= rsp_halt_in;
      rsp_div_ff   <= rsp_div_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_index_ff <= rsp_index_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[p_ff] <= mem_wd;
      end
      mem_q_ff <= mem[rd_addr];
   end

`ifndef SYNTHESIS
   a_ptr_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> p_ff >= $past(p_ff))
      else $error("slot pointer moved backward");

   a_flags_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !($past(div_ff) && !div_ff) && !($past(sat_ff) && !sat_ff) &&
                        !($past(full_ff) && !full_ff))
      else $error("sticky flag cleared");

   a_full_at_top: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(full_ff) && full_ff |-> p_ff == TOP)
      else $error("stack full flagged below the top slot");

   a_written_clears_on_advance: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(cur_wr_ff) && !cur_wr_ff |-> p_ff != $past(p_ff))
      else $error("current slot lost its written mark without an advance");
`endif

endmodule

### hw/rtl/rpn_char_stream_calculator.sv
// With the back end idle, a newline or '!' result passes the command queue, the sequencer's newline
// or halt state and the result register, which waits for the output to be free. Digits pass a
// times-ten state and an add-digit state; * and / run one bit per cycle in the shared unit.
// A 4-entry command queue lets characters be taken while the back end computes.
// Reset (synchronous, active high) clears pointer, flags and halt; slots read as zero
// and are zeroed as the pointer passes them, so no clearing pass is needed.
module rpn_char_stream_calculator #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
   parameter int FRAC_BITS   = rpn_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS   = rpn_pkg::WORD_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   rpn_req_if.sink   req_port,
   rpn_rsp_if.source rsp_port
);
   import rpn_pkg::*;

   logic                 push;
   cmd_type              push_cmd;
   logic                 queue_full;
   logic                 q_pop;
   cmd_type              q_head;
   logic                 q_empty;
   md_cmd_type           md_cmd;
   logic [WORD_BITS-1:0] md_a;
   logic [WORD_BITS-1:0] md_b;
   logic                 md_done;
   logic                 md_sat;
   logic [WORD_BITS-1:0] md_res;

   rpn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   rpn_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   rpn_muldiv #(
      .FRAC_BITS (FRAC_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_cmd (md_cmd),
      .md_a   (md_a),
      .md_b   (md_b),
      .done   (md_done),
      .sat    (md_sat),
      .res    (md_res)
   );

   rpn_exec #(
      .STACK_DEPTH (STACK_DEPTH),
      .FRAC_BITS   (FRAC_BITS),
      .WORD_BITS   (WORD_BITS)
   ) u_exec (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_port (rsp_port),
      .md_cmd   (md_cmd),
      .md_a     (md_a),
      .md_b     (md_b),
      .md_done  (md_done),
      .md_sat   (md_sat),
      .md_res   (md_res)
   );

endmodule
